FILE: design/bank_mapper_with_scanline_irq_assert.svh
// assertion macros for the bank mapper with scanline irq
// used by the top level only, expects clk and rst_n in scope
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define BMIRQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bank mapper assertion failed");

// property checked at every edge, reset included
`define BMIRQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bank mapper assertion failed");

`else

`define BMIRQ_ASSERT(lbl, prop)
`define BMIRQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: design/bmirq_pkg.sv
// shared types and constants of the bank mapper with scanline irq
// no dependencies
package bmirq_pkg;

    // kind of input word
    typedef enum logic [1:0] {
        OP_CPU_WRITE = 2'd0,
        OP_CPU_TICK  = 2'd1,
        OP_CPU_QUERY = 2'd2,
        OP_PPU_QUERY = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [1:0] CFG_CHR_MASK = 2'd1;

    // work ram window size and its offset width
    localparam int WRAM_BYTES = 8192;
    localparam int WRAM_AW    = $clog2(WRAM_BYTES);

    // cpu clocks times three per scanline
    localparam logic [9:0] PRESCALE_PERIOD = 10'd341;

    localparam int OFFSET_W = 22;

    // register write decoded for the irq unit
    typedef struct packed {
        logic       tick;
        logic       latch_wr;
        logic       ctrl_wr;
        logic       ack_wr;
        logic [7:0] data;
        logic [3:0] cycles;
    } irq_event_t;

endpackage

FILE: design/bmirq_irq.sv
// irq prescaler, counter, latch and pending flag
// depends on bmirq_pkg
module bmirq_irq
    import bmirq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  irq_event_t ev,
    output logic       pending,
    output logic       pending_next
);

    logic [7:0] reload_reg, reload_next;
    logic [7:0] counter_reg, counter_next;
    logic [8:0] prescaler_reg, prescaler_next;
    logic       enabled_reg, enabled_next;
    logic       after_ack_reg, after_ack_next;
    logic       pending_reg, pending_nxt;
    logic [5:0] add3;
    logic [9:0] sum;
    logic       wrap;

    // prescaler advance, at most one scanline per word
    assign add3 = {1'b0, ev.cycles, 1'b0} + {2'b00, ev.cycles};
    assign sum  = {1'b0, prescaler_reg} + {4'b0000, add3};
    assign wrap = (sum >= PRESCALE_PERIOD);

    // next state
    always_comb
    begin
        reload_next    = reload_reg;
        counter_next   = counter_reg;
        prescaler_next = prescaler_reg;
        enabled_next   = enabled_reg;
        after_ack_next = after_ack_reg;
        pending_nxt    = pending_reg;
        if (step)
        begin
            if (ev.tick)
            begin
                if (enabled_reg)
                begin
                    prescaler_next = wrap ? 9'(sum - PRESCALE_PERIOD) : sum[8:0];
                    if (wrap)
                    begin
                        if (counter_reg == 8'hFF)
                        begin
                            counter_next = reload_reg;
                            pending_nxt  = 1'b1;
                        end
                        else
                        begin
                            counter_next = counter_reg + 8'd1;
                        end
                    end
                end
            end
            else if (ev.latch_wr)
            begin
                reload_next = ev.data;
                pending_nxt = 1'b0;
            end
            else if (ev.ctrl_wr)
            begin
                enabled_next   = ev.data[1];
                after_ack_next = ev.data[0];
                if (ev.data[1])
                begin
                    counter_next = reload_reg;
                end
                prescaler_next = '0;
                pending_nxt    = 1'b0;
            end
            else if (ev.ack_wr)
            begin
                enabled_next = after_ack_reg;
                pending_nxt  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= '0;
            counter_reg   <= '0;
            prescaler_reg <= '0;
            enabled_reg   <= 1'b0;
            after_ack_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            reload_reg    <= reload_next;
            counter_reg   <= counter_next;
            prescaler_reg <= prescaler_next;
            enabled_reg   <= enabled_next;
            after_ack_reg <= after_ack_next;
            pending_reg   <= pending_nxt;
        end
    end

    assign pending      = pending_reg;
    assign pending_next = pending_nxt;

endmodule

FILE: design/bank_mapper_with_scanline_irq.sv
// top level of the bank mapper with scanline irq: decode, banking, result stage
// depends on bmirq_pkg, bmirq_irq and bank_mapper_with_scanline_irq_assert.svh
//
// Cartridge bank mapper with a scanline interrupt counter. Each input word is a
// cpu register write, a cpu cycle tick, a cpu address query or a ppu address
// query, and yields exactly one result word: the translated rom offset (zero for
// writes and ticks), the work ram hit flag, and the mirroring mode and irq line
// as they stand after that word. One word is accepted every clock while s_tready
// is high; a word is captured in the input register, is processed in a single
// pass that updates the bank and irq state, and is then loaded into the result
// register, from which its result is offered. The result register stalls
// only while the downstream side holds m_tready low. Configuration writes
// are taken at any time and should be issued while the block is idle.
`include "bank_mapper_with_scanline_irq_assert.svh"

module bank_mapper_with_scanline_irq
    import bmirq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], data[23:16], cycle_count[27:24], zero
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mapped_offset[21:0], wram_hit[22], mirroring[24:23],
                                   // irq_line[25], zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // input register
    logic        in_valid_reg;
    op_t         op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [3:0]  cyc_reg;

    // configuration and bank state
    logic [7:0]  prg_mask_reg;
    logic [7:0]  chr_mask_reg;
    logic [7:0]  prg16_reg;
    logic [7:0]  prg8_reg;
    logic [7:0]  chr_bank_reg [8];
    logic [1:0]  mirror_reg, mirror_next;

    // result register
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                wram_reg, wram_next;
    logic [1:0]          mirror_out_reg;
    logic                irq_out_reg;

    logic        advance;
    logic        step;
    logic [15:0] swz;
    logic [5:0]  sel;
    logic        wr;
    irq_event_t  irq_ev;
    logic        irq_pending;
    logic        irq_pending_next;
    logic [8:0]  prg16_bank;
    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank;

    // handshake
    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // input word capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= op_t'(s_tuser);
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
            cyc_reg  <= s_tdata[27:24];
        end
    end

    // register write decode, address bits 0 and 1 swapped
    assign swz = {addr_reg[15:2], addr_reg[0], addr_reg[1]};
    assign sel = {swz[15:12], swz[1:0]};
    assign wr  = (op_reg == OP_CPU_WRITE);

    assign irq_ev.tick     = (op_reg == OP_CPU_TICK);
    assign irq_ev.latch_wr = wr && (sel == 6'b1111_00);
    assign irq_ev.ctrl_wr  = wr && (sel == 6'b1111_01);
    assign irq_ev.ack_wr   = wr && (sel == 6'b1111_10);
    assign irq_ev.data     = data_reg;
    assign irq_ev.cycles   = cyc_reg;

    assign mirror_next = (step && wr && sel == 6'b1011_11) ? data_reg[3:2] : mirror_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg <= 8'hFF;
            chr_mask_reg <= 8'hFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PRG_MASK)
            begin
                prg_mask_reg <= cfg_data;
            end
            if (cfg_index == CFG_CHR_MASK)
            begin
                chr_mask_reg <= cfg_data;
            end
        end
    end

    // bank and mirroring registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg16_reg    <= '0;
            prg8_reg     <= '0;
            mirror_reg   <= '0;
            chr_bank_reg <= '{default: '0};
        end
        else
        begin
            mirror_reg <= mirror_next;
            if (step && wr)
            begin
                if (sel == 6'b1000_00)
                begin
                    prg16_reg <= data_reg;
                end
                if (sel == 6'b1100_00)
                begin
                    prg8_reg <= data_reg;
                end
                if (swz[15:12] == 4'hD)
                begin
                    chr_bank_reg[{1'b0, swz[1:0]}] <= data_reg;
                end
                if (swz[15:12] == 4'hE)
                begin
                    chr_bank_reg[{1'b1, swz[1:0]}] <= data_reg;
                end
            end
        end
    end

    // irq unit
    bmirq_irq u_irq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ev           (irq_ev),
        .pending      (irq_pending),
        .pending_next (irq_pending_next)
    );

    // address translation
    assign prg16_bank = {prg16_reg, addr_reg[13]} & {1'b0, prg_mask_reg};
    assign chr_bank   = chr_bank_reg[addr_reg[12:10]] & chr_mask_reg;

    always_comb
    begin
        priority if (!addr_reg[14])
        begin
            prg_bank = prg16_bank[7:0];
        end
        else if (!addr_reg[13])
        begin
            prg_bank = prg8_reg & prg_mask_reg;
        end
        else
        begin
            prg_bank = prg_mask_reg;
        end
    end

    always_comb
    begin
        offset_next = '0;
        wram_next   = 1'b0;
        unique case (op_reg)
            OP_CPU_QUERY:
            begin
                if (addr_reg[15:13] == 3'b011)
                begin
                    wram_next   = 1'b1;
                    offset_next = OFFSET_W'(addr_reg[WRAM_AW-1:0]);
                end
                else if (addr_reg[15])
                begin
                    offset_next = {1'b0, prg_bank, addr_reg[12:0]};
                end
            end
            OP_PPU_QUERY:
            begin
                offset_next = {4'b0000, chr_bank, addr_reg[9:0]};
            end
            default:
            begin
                offset_next = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            offset_reg     <= offset_next;
            wram_reg       <= wram_next;
            mirror_out_reg <= mirror_next;
            irq_out_reg    <= irq_pending_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, irq_out_reg, mirror_out_reg, wram_reg, offset_reg};

    // checks
    `BMIRQ_ASSERT(a_pending_rise_on_tick, $rose(irq_pending) |-> $past(step && irq_ev.tick))
    `BMIRQ_ASSERT(a_pending_clear_on_write, (step && (irq_ev.latch_wr || irq_ev.ctrl_wr || irq_ev.ack_wr)) |=> !irq_pending)
    `BMIRQ_ASSERT_ALWAYS(a_stall_only_when_full, (rst_n && !s_tready) |-> (in_valid_reg && out_valid_reg && !m_tready))

endmodule

FILE: tb/sv/bank_mapper_with_scanline_irq_tb.sv
// self-checking testbench for the bank mapper with scanline irq
// runs directed and random words against a built-in predictor of the banking and irq logic
// depends on bmirq_pkg and the bank_mapper_with_scanline_irq top level
module bank_mapper_with_scanline_irq_tb
    import bmirq_pkg::*;
();

    localparam int CLK_HIGH        = 6;
    localparam int CLK_LOW         = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 96;
    localparam int HOLDOFF_AT      = 150;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;

    // register selects as decoded, after the low address bit swap
    localparam logic [15:0] SEL_MASK      = 16'hF003;
    localparam logic [15:0] SEL_PRG16     = 16'h8000;
    localparam logic [15:0] SEL_MIRROR    = 16'hB003;
    localparam logic [15:0] SEL_PRG8      = 16'hC000;
    localparam logic [15:0] SEL_IRQ_LATCH = 16'hF000;
    localparam logic [15:0] SEL_IRQ_CTRL  = 16'hF001;
    localparam logic [15:0] SEL_IRQ_ACK   = 16'hF002;
    localparam logic [3:0]  CHR_LO_PAGE   = 4'hD;
    localparam logic [3:0]  CHR_HI_PAGE   = 4'hE;
    localparam logic [15:0] SOUND_FIRST   = 16'h9000;
    localparam logic [15:0] SOUND_LAST    = 16'hB002;

    // cpu address windows
    localparam logic [15:0] WRAM_BASE  = 16'h6000;
    localparam logic [15:0] PRG_BASE   = 16'h8000;
    localparam logic [15:0] PRG8_BASE  = 16'hC000;
    localparam logic [15:0] FIXED_BASE = 16'hE000;

    localparam logic [7:0] IRQ_COUNT_TOP = 8'hFF;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [3:0]  cycles;
    } mapper_word_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                wram_hit;
        logic [1:0]          mirroring;
        logic                irq_line;
    } mapper_result_t;

    typedef enum {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // predicted mapper state
    logic [7:0] prg_mask    = 8'hFF;
    logic [7:0] chr_mask    = 8'hFF;
    logic [7:0] prg16_bank  = '0;
    logic [7:0] prg8_bank   = '0;
    logic [7:0] chr_bank [8] = '{default: 8'h00};
    logic [1:0] mirror_sel  = '0;
    logic [7:0] irq_latch   = '0;
    logic [7:0] irq_count   = '0;
    logic       irq_en      = 1'b0;
    logic       irq_en_ack  = 1'b0;
    logic       irq_pend    = 1'b0;
    int         prescale    = 0;

    mapper_word_t   words_to_send [$];
    mapper_result_t results_due [$];

    mapper_word_t   word_on_bus;
    mapper_result_t got_word;
    mapper_result_t due_word;
    logic           send_now;
    logic           ready_now;
    int             burst_left     = 0;
    int             gap_left       = 0;
    int             words_accepted = 0;
    int             mismatches     = 0;
    int             cycles_run     = 0;
    int             rx_cycle       = 0;
    int             holdoff_left   = 0;
    logic           holdoff_done   = 1'b0;
    rx_mode_t       rx_mode        = RX_STEADY;

    bank_mapper_with_scanline_irq u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // address bits 0 and 1 trade places; the swap is its own inverse
    function automatic logic [15:0] swap_low(input logic [15:0] a);
        return {a[15:2], a[0], a[1]};
    endfunction

    function automatic void apply_cpu_write(input logic [15:0] addr, input logic [7:0] d);
        logic [15:0] a;
        logic [15:0] sel;
        a = swap_low(addr);
        // sound registers are decoded but have no effect here
        if (a >= SOUND_FIRST && a <= SOUND_LAST)
            return;
        sel = a & SEL_MASK;
        if (sel[15:12] == CHR_LO_PAGE)
            chr_bank[{1'b0, sel[1:0]}] = d;
        else if (sel[15:12] == CHR_HI_PAGE)
            chr_bank[{1'b1, sel[1:0]}] = d;
        else
        begin
            case (sel)
                SEL_PRG16:  prg16_bank = d;
                SEL_MIRROR: mirror_sel = d[3:2];
                SEL_PRG8:   prg8_bank  = d;
                SEL_IRQ_LATCH:
                begin
                    irq_latch = d;
                    irq_pend  = 1'b0;
                end
                SEL_IRQ_CTRL:
                begin
                    irq_en     = d[1];
                    irq_en_ack = d[0];
                    if (d[1])
                        irq_count = irq_latch;
                    prescale = 0;
                    irq_pend = 1'b0;
                end
                SEL_IRQ_ACK:
                begin
                    irq_en   = irq_en_ack;
                    irq_pend = 1'b0;
                end
                default: ;
            endcase
        end
    endfunction

    // three prescaler steps per cpu cycle, one counter step per scanline
    function automatic void apply_tick(input logic [3:0] n);
        if (!irq_en)
            return;
        prescale = prescale + 3 * int'(n);
        while (prescale >= int'(PRESCALE_PERIOD))
        begin
            prescale = prescale - int'(PRESCALE_PERIOD);
            if (irq_count == IRQ_COUNT_TOP)
            begin
                irq_count = irq_latch;
                irq_pend  = 1'b1;
            end
            else
                irq_count = irq_count + 8'd1;
        end
    endfunction

    function automatic mapper_result_t predict_word(input mapper_word_t w);
        mapper_result_t r;
        logic [7:0]     bank;
        logic [12:0]    ppu_addr;
        r = '0;
        case (w.op)
            OP_CPU_WRITE: apply_cpu_write(w.addr, w.data);
            OP_CPU_TICK:  apply_tick(w.cycles);
            OP_CPU_QUERY:
            begin
                if (w.addr >= WRAM_BASE && w.addr < PRG_BASE)
                begin
                    r.wram_hit = 1'b1;
                    r.offset   = OFFSET_W'((w.addr - WRAM_BASE) & 16'(WRAM_BYTES - 1));
                end
                else if (w.addr >= PRG_BASE)
                begin
                    if (w.addr < PRG8_BASE)
                        bank = {prg16_bank[6:0], w.addr[13]} & prg_mask;
                    else if (w.addr < FIXED_BASE)
                        bank = prg8_bank & prg_mask;
                    else
                        bank = prg_mask;
                    r.offset = {1'b0, bank, w.addr[12:0]};
                end
            end
            OP_PPU_QUERY:
            begin
                ppu_addr = w.addr[12:0];
                bank     = chr_bank[ppu_addr[12:10]] & chr_mask;
                r.offset = {4'b0000, bank, ppu_addr[9:0]};
            end
        endcase
        r.mirroring = mirror_sel;
        r.irq_line  = irq_pend;
        return r;
    endfunction

    function automatic mapper_word_t make_word(input op_t op, input logic [15:0] addr,
                                               input logic [7:0] data, input logic [3:0] cycles);
        mapper_word_t w;
        w.op     = op;
        w.addr   = addr;
        w.data   = data;
        w.cycles = cycles;
        return w;
    endfunction

    // raw cpu address that decodes to sel, with the don't-care bits often random
    function automatic logic [15:0] reg_addr(input logic [15:0] sel);
        logic [15:0] a;
        a = swap_low(sel);
        if ($urandom_range(0, 1) != 0)
            a[11:2] = 10'($urandom());
        return a;
    endfunction

    task automatic log_mismatch(input string what, input mapper_result_t want,
                                input mapper_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch, %s: expected offset=%h wram=%b mirror=%0d irq=%b, actual offset=%h wram=%b mirror=%0d irq=%b",
                     what, want.offset, want.wram_hit, want.mirroring, want.irq_line,
                     got.offset, got.wram_hit, got.mirroring, got.irq_line);
    endtask

    // input driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            send_now = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(predict_word(word_on_bus));
                words_accepted++;
                send_now = 1'b0;
            end
            if (!send_now)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (words_to_send.size() != 0)
                begin
                    word_on_bus = words_to_send.pop_front();
                    send_now    = 1'b1;
                    s_tdata <= {4'b0, word_on_bus.cycles, word_on_bus.data, word_on_bus.addr};
                    s_tuser <= word_on_bus.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= send_now;
        end
    end

    // result receiver: stall pattern changes now and then, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (!holdoff_done && words_accepted >= HOLDOFF_AT)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (rx_cycle % 50 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                ready_now = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: ready_now = 1'b1;
                    RX_COIN:   ready_now = ($urandom_range(0, 1) != 0);
                    RX_MOSTLY: ready_now = ($urandom_range(0, 3) != 0);
                    default:   ready_now = (rx_cycle % 7) < 4;
                endcase
            end
            m_tready <= ready_now;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.offset    = m_tdata[21:0];
            got_word.wram_hit  = m_tdata[22];
            got_word.mirroring = m_tdata[24:23];
            got_word.irq_line  = m_tdata[25];
            if (results_due.size() == 0)
                log_mismatch("result with nothing due", '0, got_word);
            else
            begin
                due_word = results_due.pop_front();
                if (got_word.offset !== due_word.offset
                    || got_word.wram_hit !== due_word.wram_hit
                    || got_word.mirroring !== due_word.mirroring
                    || got_word.irq_line !== due_word.irq_line)
                    log_mismatch("wrong field", due_word, got_word);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus: one configuration per phase, words queued for the driver
    initial
    begin
        logic [7:0] prg_masks [NUM_PHASES];
        logic [7:0] chr_masks [NUM_PHASES];
        logic [7:0] latch;
        logic [7:0] ctrl;
        mapper_word_t w;
        int queued;
        int n;
        int pick;

        prg_masks = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h1F, 8'h00};
        chr_masks = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h00};
        prg_masks[NUM_PHASES-1] = 8'($urandom());
        chr_masks[NUM_PHASES-1] = 8'($urandom());

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // both mask registers, written back to back while idle
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= CFG_PRG_MASK;
            cfg_data  <= prg_masks[ph];
            do @(posedge clk); while (!cfg_ready);
            prg_mask = prg_masks[ph];
            cfg_index <= CFG_CHR_MASK;
            cfg_data  <= chr_masks[ph];
            do @(posedge clk); while (!cfg_ready);
            chr_mask = chr_masks[ph];
            cfg_valid <= 1'b0;
            @(negedge clk);

            if (ph == 0)
            begin
                // tick while the counter is disabled
                words_to_send.push_back(make_word(OP_CPU_TICK, 16'h0000, 8'h00, 4'hF));
                // below the work ram window, then its last byte
                words_to_send.push_back(make_word(OP_CPU_QUERY, 16'h0000, 8'h00, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_QUERY, 16'h7FFF, 8'hFF, 4'hF));
                // bank registers with extreme values
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_PRG16), 8'hFF, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_PRG8), 8'h81, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, 16'hD000, 8'hFF, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, 16'hE003, 8'h5A, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_MIRROR), 8'h0C, 4'h0));
                // sound register, a write below the work ram window and an unused slot: all ignored
                words_to_send.push_back(make_word(OP_CPU_WRITE, 16'hA001, 8'h55, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, 16'h1234, 8'h77, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, 16'h8001, 8'h33, 4'h0));
                // each prg window, fixed bank at the top
                words_to_send.push_back(make_word(OP_CPU_QUERY, 16'hBFFF, 8'h00, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_QUERY, 16'hC000, 8'h00, 4'h0));
                words_to_send.push_back(make_word(OP_CPU_QUERY, 16'hFFFF, 8'h00, 4'h0));
                // ppu address past 1fff wraps
                words_to_send.push_back(make_word(OP_PPU_QUERY, 16'hFFFF, 8'h00, 4'h0));
                // latch, enable with reload, run the counter through its wrap, acknowledge
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_IRQ_LATCH), 8'hFF,
                                                  4'h0));
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_IRQ_CTRL), 8'h03,
                                                  4'h0));
                repeat (8)
                    words_to_send.push_back(make_word(OP_CPU_TICK, 16'h0000, 8'h00, 4'hF));
                words_to_send.push_back(make_word(OP_CPU_WRITE, swap_low(SEL_IRQ_ACK), 8'h00,
                                                  4'h0));
            end

            queued = 0;
            while (queued < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // irq run: latch near the top, enable, then a train of ticks
                    latch = ($urandom_range(0, 3) != 0) ? 8'hFF - 8'($urandom_range(0, 4))
                                                        : 8'($urandom());
                    ctrl = 8'($urandom());
                    if ($urandom_range(0, 4) != 0)
                        ctrl[1] = 1'b1;
                    words_to_send.push_back(make_word(OP_CPU_WRITE, reg_addr(SEL_IRQ_LATCH),
                                                      latch, 4'($urandom())));
                    words_to_send.push_back(make_word(OP_CPU_WRITE, reg_addr(SEL_IRQ_CTRL),
                                                      ctrl, 4'($urandom())));
                    n = $urandom_range(8, 40);
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            w = make_word(OP_CPU_WRITE, reg_addr(SEL_IRQ_ACK), 8'($urandom()),
                                          4'($urandom()));
                        else
                            w = make_word(OP_CPU_TICK, 16'($urandom()), 8'($urandom()),
                                          ($urandom_range(0, 3) != 0) ? 4'hF
                                                                      : 4'($urandom()));
                        words_to_send.push_back(w);
                    end
                    queued += n + 2;
                end
                else
                begin
                    // single word, every field random before shaping
                    w = make_word(op_t'($urandom_range(0, 3)), 16'($urandom()), 8'($urandom()),
                                  4'($urandom()));
                    pick = $urandom_range(0, 99);
                    if (pick < 25)
                        w.op = OP_CPU_TICK;
                    else if (pick < 50)
                    begin
                        w.op         = OP_CPU_WRITE;
                        w.addr[15:12] = 4'($urandom_range(8, 15));
                    end
                    else if (pick < 55)
                        w.op = OP_CPU_WRITE;
                    else if (pick < 78)
                        w.op = OP_CPU_QUERY;
                    else
                    begin
                        w.op = OP_PPU_QUERY;
                        if ($urandom_range(0, 3) != 0)
                            w.addr[15:13] = 3'b000;
                    end
                    words_to_send.push_back(w);
                    queued++;
                end
            end

            // sender holds off until every due result has come back
            while (words_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
